// ===== src/bsr_pkg.sv =====
// bsr_pkg: shared widths, status codes and the result type of the bisection
// square root core. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bsr_pkg;

    localparam int DATA_W   = 32;
    localparam int SQ_W     = 2 * DATA_W;
    localparam int STEP_W   = 7;
    localparam int STATUS_W = 2;

    localparam logic [STATUS_W-1:0] STATUS_TOL   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EXACT = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_CAP   = 2'd2;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [DATA_W-1:0]   root;
    } t_result;

endpackage

`default_nettype wire

// ===== src/bsr_square.sv =====
// bsr_square: shared registered squaring unit, one 32 x 32 product per cycle.
// Depends on bsr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bsr_square (
    input  wire logic                      i_clk,
    input  wire logic [bsr_pkg::DATA_W-1:0] i_a,
    output logic      [bsr_pkg::SQ_W-1:0]   o_sq
);
    import bsr_pkg::*;

    logic [SQ_W-1:0] r_sq;
    logic [SQ_W-1:0] n_sq;

    assign n_sq = SQ_W'(i_a) * SQ_W'(i_a);

    always_ff @(posedge i_clk) begin
        r_sq <= n_sq;
    end

    assign o_sq = r_sq;

endmodule

`default_nettype wire

// ===== src/bsr_seq.sv =====
// bsr_seq: bisection sequencer, bracket registers and tolerance register.
// Drives the shared squaring unit; depends on bsr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bsr_seq #(
    parameter int MAX_ITERS = 64,
    parameter int FRAC_BITS = 16
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [bsr_pkg::DATA_W-1:0] i_cfg_wdata,
    input  wire logic                       i_in_valid,
    output logic                            o_in_ready,
    input  wire logic [bsr_pkg::DATA_W-1:0] i_in_value,
    output logic      [bsr_pkg::DATA_W-1:0] o_mul_a,
    input  wire logic [bsr_pkg::SQ_W-1:0]   i_sq,
    output logic                            o_res_valid,
    input  wire logic                       i_res_ready,
    output bsr_pkg::t_result                o_res
);
    import bsr_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_MUL_LO  = 7'b0000010,
        S_MUL_HI  = 7'b0000100,
        S_CHK_LO  = 7'b0001000,
        S_CHK_HI  = 7'b0010000,
        S_CHK_MID = 7'b0100000,
        S_DONE    = 7'b1000000
    } t_state;

    localparam logic [DATA_W-1:0] ONE      = DATA_W'(1) << FRAC_BITS;
    localparam logic [STEP_W-1:0] STEP_MAX = STEP_W'(MAX_ITERS);

    t_state            r_state, n_state;
    logic [DATA_W-1:0] r_tol, n_tol;
    logic [DATA_W-1:0] r_low, n_low;
    logic [DATA_W-1:0] r_high, n_high;
    logic [DATA_W-1:0] r_mid, n_mid;
    logic [STEP_W-1:0] r_step, n_step;
    logic              r_init, n_init;
    logic [SQ_W-1:0]   r_target, n_target;
    t_result           r_res, n_res;

    logic [SQ_W-1:0]   w_tol_sh;
    logic              w_sq_gt;
    logic [SQ_W-1:0]   w_diff;
    logic [DATA_W-1:0] w_mid_lo;
    logic [DATA_W-1:0] w_mid_hi;
    logic [DATA_W-1:0] w_start_hi;

    assign w_tol_sh   = SQ_W'(r_tol) << FRAC_BITS;
    assign w_sq_gt    = i_sq > r_target;
    assign w_diff     = w_sq_gt ? (i_sq - r_target) : (r_target - i_sq);
    // both candidate midpoints are formed ahead of the compare
    assign w_mid_lo   = DATA_W'(((DATA_W+1)'(r_low) + (DATA_W+1)'(r_mid)) >> 1);
    assign w_mid_hi   = DATA_W'(((DATA_W+1)'(r_mid) + (DATA_W+1)'(r_high)) >> 1);
    assign w_start_hi = (i_in_value > ONE) ? i_in_value : ONE;

    always_comb begin
        n_state  = r_state;
        n_tol    = r_tol;
        n_low    = r_low;
        n_high   = r_high;
        n_mid    = r_mid;
        n_step   = r_step;
        n_init   = r_init;
        n_target = r_target;
        n_res    = r_res;
        o_mul_a  = r_mid;

        if (i_cfg_we) begin
            n_tol = i_cfg_wdata;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_low    = '0;
                    n_high   = w_start_hi;
                    n_mid    = w_start_hi >> 1;
                    n_step   = '0;
                    n_init   = 1'b1;
                    n_target = SQ_W'(i_in_value) << FRAC_BITS;
                    n_state  = S_MUL_LO;
                end
            end
            S_MUL_LO: begin
                o_mul_a = r_low;
                n_state = S_CHK_LO;
            end
            S_MUL_HI: begin
                o_mul_a = r_high;
                n_state = S_CHK_HI;
            end
            S_CHK_LO: begin
                // first pass also checks the upper end before the midpoint
                o_mul_a = r_init ? r_high : r_mid;
                if (i_sq == r_target) begin
                    n_res.root   = r_low;
                    n_res.status = STATUS_EXACT;
                    n_state      = S_DONE;
                end else if (r_init) begin
                    n_init  = 1'b0;
                    n_state = S_CHK_HI;
                end else begin
                    n_state = S_CHK_MID;
                end
            end
            S_CHK_HI: begin
                o_mul_a = r_mid;
                if (i_sq == r_target) begin
                    n_res.root   = r_high;
                    n_res.status = STATUS_EXACT;
                    n_state      = S_DONE;
                end else begin
                    n_state = S_CHK_MID;
                end
            end
            S_CHK_MID: begin
                if (w_diff <= w_tol_sh) begin
                    n_res.root   = r_mid;
                    n_res.status = STATUS_TOL;
                    n_state      = S_DONE;
                end else if (r_step >= STEP_MAX) begin
                    n_res.root   = r_mid;
                    n_res.status = STATUS_CAP;
                    n_state      = S_DONE;
                end else if (w_sq_gt) begin
                    // only the moved end needs its exact check again
                    n_high  = r_mid;
                    n_mid   = w_mid_lo;
                    n_step  = r_step + STEP_W'(1);
                    n_state = S_MUL_HI;
                end else begin
                    n_low   = r_mid;
                    n_mid   = w_mid_hi;
                    n_step  = r_step + STEP_W'(1);
                    n_state = S_MUL_LO;
                end
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_tol   <= DATA_W'(66);
            r_low   <= '0;
            r_high  <= '0;
            r_mid   <= '0;
            r_step  <= '0;
            r_init  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_tol   <= n_tol;
            r_low   <= n_low;
            r_high  <= n_high;
            r_mid   <= n_mid;
            r_step  <= n_step;
            r_init  <= n_init;
        end
    end

    always_ff @(posedge i_clk) begin
        r_target <= n_target;
        r_res    <= n_res;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_res       = r_res;

    a_bracket_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_low <= r_mid) && (r_mid <= r_high))
        else $error("bracket out of order");

    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step <= STEP_MAX)
        else $error("step count past cap");

    a_cap_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && (r_res.status == STATUS_CAP)) |-> (r_step == STEP_MAX))
        else $error("cap status before all steps taken");

    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_in_ready && i_in_valid) |=> (r_state == S_MUL_LO) && (r_low == '0))
        else $error("accepted beat did not start a run");

endmodule

`default_nettype wire

// ===== src/bisection_square_root_core.sv =====
// bisection_square_root_core: top level, stream ports, output register.
// Instantiates bsr_seq and bsr_square; depends on bsr_pkg.
//
// Usage:
//   s_axis carries one radicand per beat in tdata (unsigned, FRAC_BITS fraction
//   bits). m_axis returns one result per input beat: the root in tdata and a
//   status code in tuser (0 within tolerance, 1 exact bracket end, 2 step cap).
//   The tolerance register is written with i_cfg_we / i_cfg_wdata; the user
//   must write it only while idle, as the core does not enforce this. The
//   core takes one beat at a time. Each bisection step uses the single shared
//   squaring unit (square, compare end, compare midpoint); start-up first
//   squares and checks both bracket ends, and S_DONE hands over the result.
//   s_axis_tready is high only while the sequencer is idle; a finished result
//   moves into the output register, so the next beat is taken even while
//   m_axis is stalled, as long as that register is free or draining.
//   While that register is full and stalled, results wait in the sequencer.
//   Reset (synchronous, active low) clears the output valid and the bracket,
//   returns the sequencer to idle and sets the tolerance to 66.
`timescale 1ns / 1ps
`default_nettype none

module bisection_square_root_core #(
    parameter int MAX_ITERS = 64,
    parameter int FRAC_BITS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [31:0] i_cfg_wdata,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // [31:0] value
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [31:0] m_axis_tdata,   // [31:0] root
    output logic      [1:0]  m_axis_tuser    // [1:0] status
);
    import bsr_pkg::*;

    logic [DATA_W-1:0] w_mul_a;
    logic [SQ_W-1:0]   w_sq;
    logic              w_res_valid;
    logic              w_res_ready;
    t_result           w_res;

    logic              r_out_valid, n_out_valid;
    t_result           r_out, n_out;

    bsr_seq #(
        .MAX_ITERS (MAX_ITERS),
        .FRAC_BITS (FRAC_BITS)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_in_value  (s_axis_tdata),
        .o_mul_a     (w_mul_a),
        .i_sq        (w_sq),
        .o_res_valid (w_res_valid),
        .i_res_ready (w_res_ready),
        .o_res       (w_res)
    );

    bsr_square u_square (
        .i_clk (i_clk),
        .i_a   (w_mul_a),
        .o_sq  (w_sq)
    );

    // output register is free when empty or when its beat leaves this cycle
    assign w_res_ready = !r_out_valid || m_axis_tready;

    always_comb begin
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (w_res_valid && w_res_ready) begin
            n_out_valid = 1'b1;
            n_out       = w_res;
        end else if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out.root;
    assign m_axis_tuser  = r_out.status;

endmodule

`default_nettype wire

// ===== verif/tb_bisection_square_root_core.sv =====
// tb_bisection_square_root_core: self-checking testbench for the bisection square root
// core, with a scoreboard class holding its own bisection predictor, plus stream drivers.
// Depends on bsr_pkg and bisection_square_root_core.
`timescale 1ns / 1ps

module tb_bisection_square_root_core;
    import bsr_pkg::*;

    localparam int MAX_STEPS   = 64;
    localparam int FRAC        = 16;
    localparam int CYCLE_LIMIT = 1_500_000;
    localparam int HOLD_AT     = 400;
    localparam int HOLD_CYCLES = 800;
    localparam int BURST_FIRST = 700;
    localparam int BURST_LAST  = 850;
    localparam int PHASE_ITEMS = 180;
    localparam logic [31:0] TOL_RESET = 32'd66;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [31:0] i_cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // [31:0] value
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // [31:0] root
    logic [1:0]  m_axis_tuser;   // [1:0] status

    class root_scoreboard;
        t_result     expected_roots[$];
        logic [31:0] tolerance;
        int          errors;

        function new();
            tolerance = TOL_RESET;
            errors    = 0;
        endfunction

        function void set_tolerance(logic [31:0] tol);
            tolerance = tol;
        endfunction

        function int pending();
            return expected_roots.size();
        endfunction

        function logic [63:0] square(logic [31:0] x);
            return {32'b0, x} * {32'b0, x};
        endfunction

        function logic [31:0] halfway(logic [31:0] a, logic [31:0] b);
            logic [32:0] sum;
            sum = {1'b0, a} + {1'b0, b};
            return sum[32:1];
        endfunction

        // low end is tried before high end
        function bit exact_end(logic [31:0] lo, logic [31:0] hi, logic [63:0] target,
                               output logic [31:0] hit);
            hit = '0;
            if (square(lo) == target) begin
                hit = lo;
                return 1'b1;
            end
            if (square(hi) == target) begin
                hit = hi;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function t_result bisect_root(logic [31:0] v);
            logic [63:0] target;
            logic [63:0] tol;
            logic [63:0] sq_mid;
            logic [63:0] diff;
            logic [31:0] one;
            logic [31:0] lo;
            logic [31:0] hi;
            logic [31:0] mid;
            logic [31:0] hit;
            t_result     res;
            target = {32'b0, v} << FRAC;
            tol    = {32'b0, tolerance} << FRAC;
            one    = 32'd1 << FRAC;
            lo     = '0;
            hi     = (v > one) ? v : one;
            mid    = halfway(lo, hi);
            res.status = STATUS_EXACT;
            res.root   = '0;
            if (exact_end(lo, hi, target, hit)) begin
                res.root = hit;
                return res;
            end
            for (int step = 0; step <= MAX_STEPS; step++) begin
                sq_mid = square(mid);
                diff   = (sq_mid > target) ? (sq_mid - target) : (target - sq_mid);
                if (diff <= tol) begin
                    res.status = STATUS_TOL;
                    res.root   = mid;
                    return res;
                end
                if (step >= MAX_STEPS) begin
                    res.status = STATUS_CAP;
                    res.root   = mid;
                    return res;
                end
                if (sq_mid > target) hi = mid;
                else lo = mid;
                mid = halfway(lo, hi);
                if (exact_end(lo, hi, target, hit)) begin
                    res.status = STATUS_EXACT;
                    res.root   = hit;
                    return res;
                end
            end
            return res;
        endfunction

        function void note_radicand(logic [31:0] v);
            expected_roots.push_back(bisect_root(v));
        endfunction

        task report(string what);
            $display("mismatch @%0t: %s", $realtime, what);
            errors++;
        endtask

        task check_root(logic [31:0] root, logic [1:0] status);
            t_result want;
            if (expected_roots.size() == 0) begin
                report($sformatf("unexpected result root=%h status=%0d", root, status));
                return;
            end
            want = expected_roots.pop_front();
            if (root !== want.root)
                report($sformatf("root got %h want %h", root, want.root));
            if (status !== want.status)
                report($sformatf("status got %0d want %0d (root %h)", status, want.status,
                                 want.root));
        endtask
    endclass

    root_scoreboard sb;
    int n_sent;
    int n_results = 0;
    int cycles = 0;

    bisection_square_root_core #(
        .MAX_ITERS(MAX_STEPS),
        .FRAC_BITS(FRAC)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // stretches with no idling on either side
    function automatic int draw_wait(int idx);
        if (idx >= BURST_FIRST && idx < BURST_LAST) return 0;
        return $urandom_range(0, 12);
    endfunction

    function automatic logic [31:0] gen_radicand();
        logic [31:0] k;
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $urandom_range(0, 32'h0000_FFFF);
            2: begin
                k = $urandom_range(0, 32'h0000_FFFF);
                return k * k;
            end
            3: return 32'h0001_0000 + $urandom_range(0, 512) - 256;
            4: return $urandom >> $urandom_range(0, 31);
            default: return 32'hFFFF_0000 | $urandom_range(0, 32'h0000_FFFF);
        endcase
    endfunction

    // entered and left at a falling edge
    task automatic send_radicand(logic [31:0] v);
        int gap;
        gap = draw_wait(n_sent);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= v;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_radicand(v);
        n_sent++;
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (sb.pending() != 0);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic write_tolerance(logic [31:0] tol);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= tol;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.set_tolerance(tol);
        repeat (2) @(negedge i_clk);
    endtask

    task automatic run_random_phase(logic [31:0] tol, int count);
        wait_idle();
        write_tolerance(tol);
        repeat (count) send_radicand(gen_radicand());
    endtask

    // result side, including one long hold-off so the core backs up
    initial begin
        int stall;
        m_axis_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            stall = (n_results == HOLD_AT) ? HOLD_CYCLES : draw_wait(n_results);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            sb.check_root(m_axis_tdata, m_axis_tuser);
            n_results++;
            @(negedge i_clk);
        end
    end

    initial begin
        logic [31:0] directed [13];
        logic [31:0] phase_tol [8];
        directed = '{32'h0000_0000, 32'h0000_0001, 32'h0000_FFFF, 32'h0001_0000,
                     32'h0001_0001, 32'h0002_0000, 32'h0002_4000, 32'h0004_0000,
                     32'h0009_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
                     32'h0000_4000};
        sb            = new();
        n_sent        = 0;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset tolerance first, then zero tolerance and the widest one
        foreach (directed[i]) send_radicand(directed[i]);
        wait_idle();
        write_tolerance(32'h0000_0000);
        for (int i = 0; i < 6; i++) send_radicand(directed[i + 1]);
        wait_idle();
        write_tolerance(32'hFFFF_FFFF);
        for (int i = 8; i < 12; i++) send_radicand(directed[i]);

        phase_tol = '{32'h0000_0000, TOL_RESET, 32'hFFFF_FFFF, 32'h0000_0001, $urandom,
                      32'h0001_0000, 32'h8000_0000, $urandom_range(0, 4096)};
        foreach (phase_tol[i]) run_random_phase(phase_tol[i], PHASE_ITEMS);

        wait_idle();
        repeat (250) @(negedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
